@@ rtl/core/hst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and constants for the hashed symbol table: controller states,
// operation and status codes, and the fixed hash arithmetic.
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned KEY_W  = 31;
    localparam int unsigned ADDR_W = 32;

    localparam logic [HASH_W-1:0] HASH_MULT = 32'd131;

    // The serial bucket reduction takes this many key bits per cycle.
    localparam int unsigned MOD_BITS  = 4;
    localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DUP  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_HEAD_RD,
        ST_HEAD,
        ST_NODE,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/hst_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hst_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module hst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/hashed_symbol_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_symbol_table
// Symbol table keyed by a multiplicative string hash, with chained buckets.
// A name byte that is not the last only updates the running hash. The last
// byte starts the lookup: a serial reduction of the key to a bucket when
// BUCKETS is not a power of two, a head read, then a chain walk that issues
// one node RAM read per cycle. One name is processed at a time.
// After reset a clearing pass empties the bucket heads before the first name
// byte is accepted.
// ----------------------------------------------------------------------------
module hashed_symbol_table #(
    parameter int unsigned BUCKETS = 128,
    parameter int unsigned NODES   = 256
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_mode,
    input  wire  [7:0]  s_name_byte,
    input  wire         s_name_last,
    input  wire  [31:0] s_value,

    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_found,
    output logic [31:0] m_address,
    output logic [1:0]  m_status
);

    localparam int unsigned BW  = $clog2(BUCKETS);
    localparam int unsigned NIW = $clog2(NODES);
    localparam int unsigned UW  = $clog2(NODES + 1);
    localparam int unsigned SW  = $clog2(hst_pkg::MOD_STEPS);
    localparam bit BKT_POW2     = ((BUCKETS & (BUCKETS - 1)) == 0);

    localparam int unsigned HEAD_W = NIW + 1;
    // Node word: {key, address, link valid, link index}.
    localparam int unsigned NODE_W = hst_pkg::KEY_W + hst_pkg::ADDR_W + 1 + NIW;

    hst_pkg::state_t state_reg, state_next;

    logic [hst_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [hst_pkg::KEY_W-1:0]  key_reg, key_next;
    logic                       mode_reg, mode_next;
    logic [31:0]                value_reg, value_next;
    logic [BW-1:0]              bucket_reg, bucket_next;
    logic [hst_pkg::HASH_W-1:0] shift_reg, shift_next;
    logic [SW-1:0]              step_reg, step_next;
    logic [BW-1:0]              clr_reg, clr_next;
    logic                       hv_reg, hv_next;
    logic [NIW-1:0]             hidx_reg, hidx_next;
    logic                       hit_reg, hit_next;
    logic [31:0]                hit_addr_reg, hit_addr_next;
    logic [UW-1:0]              used_reg, used_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       found_reg, found_next;
    logic [31:0]                address_reg, address_next;
    logic [1:0]                 status_reg, status_next;

    logic                       head_we;
    logic [BW-1:0]              head_waddr;
    logic [HEAD_W-1:0]          head_wdata;
    logic [BW-1:0]              head_raddr;
    logic [HEAD_W-1:0]          head_rdata;

    logic                       node_we;
    logic [NIW-1:0]             node_waddr;
    logic [NODE_W-1:0]          node_wdata;
    logic [NIW-1:0]             node_raddr;
    logic [NODE_W-1:0]          node_rdata;

    logic [hst_pkg::KEY_W-1:0]  nd_key;
    logic [31:0]                nd_addr;
    logic                       nd_link_v;
    logic [NIW-1:0]             nd_link_idx;

    logic [hst_pkg::HASH_W-1:0] hash_upd;
    logic [BW-1:0]              bucket_step;
    logic                       pool_full;

    hst_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    hst_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign {nd_key, nd_addr, nd_link_v, nd_link_idx} = node_rdata;

    assign hash_upd  = hash_reg * hst_pkg::HASH_MULT + {24'd0, s_name_byte};
    assign pool_full = (used_reg == UW'(NODES));

    // Restoring remainder over MOD_BITS key bits, most significant first.
    always_comb begin
        logic [BW:0] r;
        r = {1'b0, bucket_reg};
        for (int i = 0; i < hst_pkg::MOD_BITS; i++) begin
            r = {r[BW-1:0], shift_reg[hst_pkg::HASH_W-1-i]};
            if (r >= (BW+1)'(BUCKETS)) begin
                r = r - (BW+1)'(BUCKETS);
            end
        end
        bucket_step = r[BW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hst_pkg::ST_CLEAR;
            hash_reg    <= '0;
            step_reg    <= '0;
            clr_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            step_reg    <= step_next;
            clr_reg     <= clr_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg      <= key_next;
        mode_reg     <= mode_next;
        value_reg    <= value_next;
        bucket_reg   <= bucket_next;
        shift_reg    <= shift_next;
        hv_reg       <= hv_next;
        hidx_reg     <= hidx_next;
        hit_reg      <= hit_next;
        hit_addr_reg <= hit_addr_next;
        found_reg    <= found_next;
        address_reg  <= address_next;
        status_reg   <= status_next;
    end

    always_comb begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        key_next      = key_reg;
        mode_next     = mode_reg;
        value_next    = value_reg;
        bucket_next   = bucket_reg;
        shift_next    = shift_reg;
        step_next     = step_reg;
        clr_next      = clr_reg;
        hv_next       = hv_reg;
        hidx_next     = hidx_reg;
        hit_next      = hit_reg;
        hit_addr_next = hit_addr_reg;
        used_next     = used_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        found_next    = found_reg;
        address_next  = address_reg;
        status_next   = status_reg;

        s_ready    = 1'b0;
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = {1'b1, used_reg[NIW-1:0]};
        head_raddr = bucket_reg;
        node_we    = 1'b0;
        node_waddr = used_reg[NIW-1:0];
        node_wdata = {key_reg, value_reg, hv_reg, hidx_reg};
        node_raddr = nd_link_idx;

        unique case (state_reg)
            hst_pkg::ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = hst_pkg::ST_IDLE;
                end
            end
            hst_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    hash_next = hash_upd;
                    if (s_name_last) begin
                        hash_next  = '0;
                        key_next   = hash_upd[hst_pkg::KEY_W-1:0];
                        mode_next  = s_mode;
                        value_next = s_value;
                        if (BKT_POW2) begin
                            bucket_next = hash_upd[BW-1:0];
                            state_next  = hst_pkg::ST_HEAD_RD;
                        end else begin
                            bucket_next = '0;
                            shift_next  = {1'b0, hash_upd[hst_pkg::KEY_W-1:0]};
                            step_next   = '0;
                            state_next  = hst_pkg::ST_REDUCE;
                        end
                    end
                end
            end
            hst_pkg::ST_REDUCE: begin
                bucket_next = bucket_step;
                shift_next  = shift_reg << hst_pkg::MOD_BITS;
                step_next   = step_reg + 1'b1;
                if (step_reg == SW'(hst_pkg::MOD_STEPS - 1)) begin
                    state_next = hst_pkg::ST_HEAD_RD;
                end
            end
            hst_pkg::ST_HEAD_RD: begin
                // Head read is issued here; its data is seen in the next state.
                state_next = hst_pkg::ST_HEAD;
            end
            hst_pkg::ST_HEAD: begin
                hv_next    = head_rdata[NIW];
                hidx_next  = head_rdata[NIW-1:0];
                hit_next   = 1'b0;
                node_raddr = head_rdata[NIW-1:0];
                if (head_rdata[NIW]) begin
                    state_next = hst_pkg::ST_NODE;
                end else begin
                    state_next = hst_pkg::ST_FINISH;
                end
            end
            hst_pkg::ST_NODE: begin
                node_raddr = nd_link_idx;
                if (nd_key == key_reg) begin
                    hit_next      = 1'b1;
                    hit_addr_next = nd_addr;
                    state_next    = hst_pkg::ST_FINISH;
                end else if (!nd_link_v) begin
                    state_next = hst_pkg::ST_FINISH;
                end
            end
            hst_pkg::ST_FINISH: begin
                // Hold here until the output register is free for the new word.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = hst_pkg::ST_IDLE;
                    if (mode_reg == hst_pkg::MODE_INSERT) begin
                        found_next   = 1'b0;
                        address_next = '0;
                        if (hit_reg) begin
                            status_next = hst_pkg::STATUS_DUP;
                        end else if (pool_full) begin
                            status_next = hst_pkg::STATUS_FULL;
                        end else begin
                            status_next = hst_pkg::STATUS_OK;
                            node_we     = 1'b1;
                            head_we     = 1'b1;
                            used_next   = used_reg + 1'b1;
                        end
                    end else begin
                        found_next   = hit_reg;
                        address_next = hit_reg ? hit_addr_reg : 32'd0;
                        status_next  = hst_pkg::STATUS_OK;
                    end
                end
            end
            default: begin
                state_next = hst_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_found   = found_reg;
    assign m_address = address_reg;
    assign m_status  = status_reg;

endmodule
`default_nettype wire
